// ===== rtl/core/spss_pkg.sv =====
// Package for the servo preset slew sequencer.
// Holds sizes, reset values, command and phase codes and shared helpers.
// No dependencies.
package spss_pkg;

  localparam int unsigned PRESET_COUNT = 3;
  localparam int unsigned ANGLE_W      = 8;
  localparam int unsigned SLOT_W       = 2;
  localparam int unsigned CMD_W        = 2;
  localparam int unsigned CFG_IDX_W    = 2;

  localparam logic [ANGLE_W-1:0] ANGLE_MAX       = 8'd180;
  localparam logic [ANGLE_W-1:0] LIFT_RESET      = 8'd130;
  localparam logic [ANGLE_W-1:0] CENTRE_H_RESET  = 8'd90;
  localparam logic [ANGLE_W-1:0] CENTRE_V_RESET  = 8'd45;

  typedef logic [ANGLE_W-1:0] angle_t;

  typedef enum logic [CMD_W-1:0] {
    CMD_TICK   = 2'd0,
    CMD_GO     = 2'd1,
    CMD_CENTRE = 2'd2,
    CMD_STORE  = 2'd3
  } cmd_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_LIFT     = 2'd0,
    CFG_CENTRE_H = 2'd1,
    CFG_CENTRE_V = 2'd2,
    CFG_NONE     = 2'd3
  } cfg_idx_e;

  typedef enum logic [3:0] {
    PH_IDLE  = 4'b0001,
    PH_LIFT  = 4'b0010,
    PH_HSLEW = 4'b0100,
    PH_VSLEW = 4'b1000
  } phase_e;

  function automatic angle_t sat_angle(input angle_t v);
    return (v > ANGLE_MAX) ? ANGLE_MAX : v;
  endfunction

  function automatic phase_e next_phase(input phase_e ph);
    phase_e nx;
    unique case (ph)
      PH_LIFT:  nx = PH_HSLEW;
      PH_HSLEW: nx = PH_VSLEW;
      PH_VSLEW: nx = PH_IDLE;
      default:  nx = PH_IDLE;
    endcase
    return nx;
  endfunction

endpackage

// ===== rtl/core/servo_preset_slew_sequencer.sv =====
// Top level of the servo preset slew sequencer: input register, command
// logic, angle/preset state and result register.
// Depends on spss_pkg.
//
// Usage: one word in (cmd, preset_select, horizontal_value, vertical_value),
// one word out (horizontal_angle, vertical_angle, busy_res, accepted) per
// input word, in order. Both channels use valid/stall; a word moves when
// valid is high and stall is low.
// An accepted word sits in the input register and its result is loaded into
// the output register when that register is empty or not stalled. Throughput
// is one word per cycle while the output is not stalled; the state update
// (step, phase skip, centre, store) is one pass of compare and increment
// logic between the two registers.
// A stall on the output holds the result register and then the input
// register; in_stall_o rises only when both are full. Reset puts both angles
// at the centre reset values, clears the presets, returns to idle and loads
// the register reset values. Registers are to be written through cfg_we_i/
// cfg_index_i/cfg_data_i only while idle; the block does not enforce this.
module servo_preset_slew_sequencer (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [spss_pkg::CMD_W-1:0]     cmd_i,
  input  logic [spss_pkg::SLOT_W-1:0]    preset_select_i,
  input  logic [spss_pkg::ANGLE_W-1:0]   horizontal_value_i,
  input  logic [spss_pkg::ANGLE_W-1:0]   vertical_value_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [spss_pkg::ANGLE_W-1:0]   horizontal_angle_o,
  output logic [spss_pkg::ANGLE_W-1:0]   vertical_angle_o,
  output logic                           busy_res_o,
  output logic                           accepted_o,
  input  logic                           cfg_we_i,
  input  logic [spss_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [spss_pkg::ANGLE_W-1:0]   cfg_data_i
);

  // configuration, stored saturated
  spss_pkg::angle_t lift_q, centre_h_q, centre_v_q;

  // input register
  logic                        in_valid_q;
  spss_pkg::cmd_e              cmd_q;
  logic [spss_pkg::SLOT_W-1:0] sel_q;
  spss_pkg::angle_t            hval_q, vval_q;

  // state
  spss_pkg::angle_t            h_q, v_q, h_d, v_d;
  spss_pkg::phase_e            phase_q, phase_d;
  logic [spss_pkg::SLOT_W-1:0] active_q, active_d;
  spss_pkg::angle_t            ph_q [spss_pkg::PRESET_COUNT];
  spss_pkg::angle_t            pv_q [spss_pkg::PRESET_COUNT];

  // output register
  logic             out_valid_q;
  spss_pkg::angle_t out_h_q, out_v_q;
  logic             out_busy_q, out_acc_q;

  logic                        adv, fire, acc_in;
  logic [spss_pkg::SLOT_W-1:0] slot;
  logic                        slot_ok, sel_ok, idle;
  spss_pkg::angle_t            tgt_h, tgt_v, axis, tgt, stepped, h_s, v_s;
  spss_pkg::phase_e            pre_phase, pass_phase;
  logic                        do_store, acc_d;

  assign adv        = !out_valid_q || !out_stall_i;
  assign fire       = in_valid_q && adv;
  assign in_stall_o = in_valid_q && !adv;
  assign acc_in     = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lift_q     <= spss_pkg::LIFT_RESET;
      centre_h_q <= spss_pkg::CENTRE_H_RESET;
      centre_v_q <= spss_pkg::CENTRE_V_RESET;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        spss_pkg::CFG_LIFT:     lift_q     <= spss_pkg::sat_angle(cfg_data_i);
        spss_pkg::CFG_CENTRE_H: centre_h_q <= spss_pkg::sat_angle(cfg_data_i);
        spss_pkg::CFG_CENTRE_V: centre_v_q <= spss_pkg::sat_angle(cfg_data_i);
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= acc_in || (in_valid_q && !adv);
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc_in) begin
      cmd_q  <= spss_pkg::cmd_e'(cmd_i);
      sel_q  <= preset_select_i;
      hval_q <= horizontal_value_i;
      vval_q <= vertical_value_i;
    end
  end

  // preset read: new slot on go, running slot otherwise
  assign idle    = (phase_q == spss_pkg::PH_IDLE);
  assign sel_ok  = ({1'b0, sel_q} < (spss_pkg::SLOT_W + 1)'(spss_pkg::PRESET_COUNT));
  assign slot    = (cmd_q == spss_pkg::CMD_GO) ? sel_q : active_q;
  assign slot_ok = ({1'b0, slot} < (spss_pkg::SLOT_W + 1)'(spss_pkg::PRESET_COUNT));
  assign tgt_h   = slot_ok ? ph_q[slot] : ph_q[0];
  assign tgt_v   = slot_ok ? pv_q[slot] : pv_q[0];

  always_comb begin
    axis = (phase_q == spss_pkg::PH_HSLEW) ? h_q : v_q;
    case (phase_q)
      spss_pkg::PH_LIFT:  tgt = lift_q;
      spss_pkg::PH_HSLEW: tgt = tgt_h;
      default:            tgt = tgt_v;
    endcase
    if (axis < tgt) begin
      stepped = axis + 8'd1;
    end else if (axis > tgt) begin
      stepped = axis - 8'd1;
    end else begin
      stepped = axis;
    end
  end

  // pass phases whose axis already sits on target
  function automatic spss_pkg::phase_e pass_done(
    input spss_pkg::phase_e ph_in,
    input spss_pkg::angle_t h,
    input spss_pkg::angle_t v,
    input spss_pkg::angle_t lift,
    input spss_pkg::angle_t th,
    input spss_pkg::angle_t tv
  );
    spss_pkg::phase_e ph;
    logic             hit;
    ph = ph_in;
    for (int i = 0; i < 3; i++) begin
      case (ph)
        spss_pkg::PH_LIFT:  hit = (v == lift);
        spss_pkg::PH_HSLEW: hit = (h == th);
        spss_pkg::PH_VSLEW: hit = (v == tv);
        default:            hit = 1'b0;
      endcase
      if (hit) begin
        ph = spss_pkg::next_phase(ph);
      end
    end
    return ph;
  endfunction

  always_comb begin
    h_s = h_q;
    v_s = v_q;
    if (cmd_q == spss_pkg::CMD_TICK && !idle) begin
      if (phase_q == spss_pkg::PH_HSLEW) begin
        h_s = stepped;
      end else begin
        v_s = stepped;
      end
    end
    pre_phase  = (cmd_q == spss_pkg::CMD_TICK) ? phase_q : spss_pkg::PH_LIFT;
    pass_phase = pass_done(pre_phase, h_s, v_s, lift_q, tgt_h, tgt_v);

    h_d      = h_q;
    v_d      = v_q;
    phase_d  = phase_q;
    active_d = active_q;
    do_store = 1'b0;
    acc_d    = 1'b0;
    case (cmd_q)
      spss_pkg::CMD_TICK: begin
        h_d     = h_s;
        v_d     = v_s;
        phase_d = pass_phase;
        acc_d   = 1'b1;
      end
      spss_pkg::CMD_CENTRE: begin
        if (idle) begin
          h_d   = centre_h_q;
          v_d   = centre_v_q;
          acc_d = 1'b1;
        end
      end
      spss_pkg::CMD_GO: begin
        if (idle && sel_ok) begin
          active_d = sel_q;
          phase_d  = pass_phase;
          acc_d    = 1'b1;
        end
      end
      default: begin
        if (idle && sel_ok) begin
          do_store = 1'b1;
          acc_d    = 1'b1;
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      h_q      <= spss_pkg::CENTRE_H_RESET;
      v_q      <= spss_pkg::CENTRE_V_RESET;
      phase_q  <= spss_pkg::PH_IDLE;
      active_q <= '0;
      for (int k = 0; k < spss_pkg::PRESET_COUNT; k++) begin
        ph_q[k] <= '0;
        pv_q[k] <= '0;
      end
    end else if (fire) begin
      h_q      <= h_d;
      v_q      <= v_d;
      phase_q  <= phase_d;
      active_q <= active_d;
      if (do_store) begin
        ph_q[sel_q] <= spss_pkg::sat_angle(hval_q);
        pv_q[sel_q] <= spss_pkg::sat_angle(vval_q);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= fire || (out_valid_q && out_stall_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      out_h_q    <= h_d;
      out_v_q    <= v_d;
      out_busy_q <= (phase_d != spss_pkg::PH_IDLE);
      out_acc_q  <= acc_d;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign horizontal_angle_o = out_h_q;
  assign vertical_angle_o   = out_v_q;
  assign busy_res_o         = out_busy_q;
  assign accepted_o         = out_acc_q;

  a_result_tracks_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire |=> out_valid_o && horizontal_angle_o == h_q && vertical_angle_o == v_q)
    else $error("result word does not match updated angles");

  a_busy_tracks_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire |=> busy_res_o == (phase_q != spss_pkg::PH_IDLE))
    else $error("busy flag disagrees with phase");

  a_tick_always_taken: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire && cmd_q == spss_pkg::CMD_TICK |=> accepted_o)
    else $error("tick word reported as ignored");

  a_held_word_kept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q && !adv |=> in_valid_q && $stable(cmd_q))
    else $error("held input word lost");

endmodule

// ===== sim/tb_top.sv =====
`timescale 1ns / 100ps
// Testbench for servo_preset_slew_sequencer: a directed table, then random preset moves
// under three idle/stall mixes, with a self-contained predictor and in-order word checks.
// Depends on spss_pkg and the servo_preset_slew_sequencer RTL.
module tb_top;

  localparam int unsigned CYCLE_LIMIT = 200_000;
  localparam int unsigned HOLD_CYCLES = 80;
  localparam int unsigned PHASE_WORDS = 240;
  localparam int unsigned PLAN_LEN    = 25;

  typedef logic [spss_pkg::SLOT_W-1:0] slot_t;

  typedef struct packed {
    spss_pkg::angle_t hor;
    spss_pkg::angle_t ver;
    logic             busy;
    logic             acc;
  } servo_word_t;

  typedef struct packed {
    logic               is_reg;
    spss_pkg::cfg_idx_e reg_idx;
    spss_pkg::cmd_e     cmd;
    slot_t              sel;
    spss_pkg::angle_t   hval;
    spss_pkg::angle_t   vval;
    logic               typed;
    servo_word_t        want;
  } plan_row_t;

  // Register rows carry their data in hval.
  localparam plan_row_t PLAN [PLAN_LEN] = '{
    '{1'b0, spss_pkg::CFG_NONE, spss_pkg::CMD_TICK,   2'd0, 8'd0,   8'd0,
      1'b1, '{8'd90,  8'd45,  1'b0, 1'b1}},
    '{1'b0, spss_pkg::CFG_NONE, spss_pkg::CMD_CENTRE, 2'd0, 8'd0,   8'd0,
      1'b1, '{8'd90,  8'd45,  1'b0, 1'b1}},
    '{1'b0, spss_pkg::CFG_NONE, spss_pkg::CMD_STORE,  2'd3, 8'd255, 8'd255,
      1'b1, '{8'd90,  8'd45,  1'b0, 1'b0}},
    '{1'b0, spss_pkg::CFG_NONE, spss_pkg::CMD_GO,     2'd3, 8'd0,   8'd0,
      1'b1, '{8'd90,  8'd45,  1'b0, 1'b0}},
    '{1'b0, spss_pkg::CFG_NONE, spss_pkg::CMD_STORE,  2'd0, 8'd255, 8'd255,
      1'b1, '{8'd90,  8'd45,  1'b0, 1'b1}},
    '{1'b0, spss_pkg::CFG_NONE, spss_pkg::CMD_STORE,  2'd1, 8'd0,   8'd0,
      1'b1, '{8'd90,  8'd45,  1'b0, 1'b1}},
    '{1'b1, spss_pkg::CFG_CENTRE_V, spss_pkg::CMD_TICK, 2'd0, 8'd128, 8'd0,
      1'b0, '0},
    '{1'b1, spss_pkg::CFG_CENTRE_H, spss_pkg::CMD_TICK, 2'd0, 8'd255, 8'd0,
      1'b0, '0},
    '{1'b0, spss_pkg::CFG_NONE, spss_pkg::CMD_CENTRE, 2'd0, 8'd0,   8'd0,
      1'b1, '{8'd180, 8'd128, 1'b0, 1'b1}},
    '{1'b0, spss_pkg::CFG_NONE, spss_pkg::CMD_STORE,  2'd2, 8'd179, 8'd130,
      1'b1, '{8'd180, 8'd128, 1'b0, 1'b1}},
    '{1'b0, spss_pkg::CFG_NONE, spss_pkg::CMD_GO,     2'd2, 8'd0,   8'd0,
      1'b1, '{8'd180, 8'd128, 1'b1, 1'b1}},
    '{1'b0, spss_pkg::CFG_NONE, spss_pkg::CMD_CENTRE, 2'd0, 8'd0,   8'd0,
      1'b1, '{8'd180, 8'd128, 1'b1, 1'b0}},
    '{1'b0, spss_pkg::CFG_NONE, spss_pkg::CMD_STORE,  2'd0, 8'd7,   8'd7,
      1'b1, '{8'd180, 8'd128, 1'b1, 1'b0}},
    '{1'b0, spss_pkg::CFG_NONE, spss_pkg::CMD_TICK,   2'd0, 8'd0,   8'd0,
      1'b1, '{8'd180, 8'd129, 1'b1, 1'b1}},
    '{1'b0, spss_pkg::CFG_NONE, spss_pkg::CMD_TICK,   2'd0, 8'd0,   8'd0,
      1'b1, '{8'd180, 8'd130, 1'b1, 1'b1}},
    '{1'b0, spss_pkg::CFG_NONE, spss_pkg::CMD_TICK,   2'd0, 8'd0,   8'd0,
      1'b1, '{8'd179, 8'd130, 1'b0, 1'b1}},
    '{1'b0, spss_pkg::CFG_NONE, spss_pkg::CMD_GO,     2'd2, 8'd0,   8'd0,
      1'b1, '{8'd179, 8'd130, 1'b0, 1'b1}},
    '{1'b1, spss_pkg::CFG_LIFT,     spss_pkg::CMD_TICK, 2'd0, 8'd255, 8'd0,
      1'b0, '0},
    '{1'b1, spss_pkg::CFG_CENTRE_V, spss_pkg::CMD_TICK, 2'd0, 8'd178, 8'd0,
      1'b0, '0},
    '{1'b1, spss_pkg::CFG_NONE,     spss_pkg::CMD_TICK, 2'd0, 8'd0,   8'd0,
      1'b0, '0},
    '{1'b0, spss_pkg::CFG_NONE, spss_pkg::CMD_CENTRE, 2'd0, 8'd0,   8'd0,
      1'b1, '{8'd180, 8'd178, 1'b0, 1'b1}},
    '{1'b0, spss_pkg::CFG_NONE, spss_pkg::CMD_GO,     2'd0, 8'd0,   8'd0,
      1'b1, '{8'd180, 8'd178, 1'b1, 1'b1}},
    '{1'b0, spss_pkg::CFG_NONE, spss_pkg::CMD_TICK,   2'd0, 8'd0,   8'd0,
      1'b1, '{8'd180, 8'd179, 1'b1, 1'b1}},
    '{1'b0, spss_pkg::CFG_NONE, spss_pkg::CMD_TICK,   2'd0, 8'd0,   8'd0,
      1'b1, '{8'd180, 8'd180, 1'b0, 1'b1}},
    '{1'b0, spss_pkg::CFG_NONE, spss_pkg::CMD_TICK,   2'd0, 8'd0,   8'd0,
      1'b1, '{8'd180, 8'd180, 1'b0, 1'b1}}
  };

  logic                           clk_i;
  logic                           rst_ni;
  logic                           in_valid_i;
  logic                           in_stall_o;
  logic [spss_pkg::CMD_W-1:0]     cmd_i;
  slot_t                          preset_select_i;
  spss_pkg::angle_t               horizontal_value_i;
  spss_pkg::angle_t               vertical_value_i;
  logic                           out_valid_o;
  logic                           out_stall_i;
  spss_pkg::angle_t               horizontal_angle_o;
  spss_pkg::angle_t               vertical_angle_o;
  logic                           busy_res_o;
  logic                           accepted_o;
  logic                           cfg_we_i;
  logic [spss_pkg::CFG_IDX_W-1:0] cfg_index_i;
  spss_pkg::angle_t               cfg_data_i;

  servo_preset_slew_sequencer dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_valid_i),
    .in_stall_o         (in_stall_o),
    .cmd_i              (cmd_i),
    .preset_select_i    (preset_select_i),
    .horizontal_value_i (horizontal_value_i),
    .vertical_value_i   (vertical_value_i),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .horizontal_angle_o (horizontal_angle_o),
    .vertical_angle_o   (vertical_angle_o),
    .busy_res_o         (busy_res_o),
    .accepted_o         (accepted_o),
    .cfg_we_i           (cfg_we_i),
    .cfg_index_i        (cfg_index_i),
    .cfg_data_i         (cfg_data_i)
  );

  // Predicted block state
  spss_pkg::angle_t lift_reg, centre_h_reg, centre_v_reg;
  spss_pkg::angle_t pos_h, pos_v;
  spss_pkg::angle_t preset_mem [2*spss_pkg::PRESET_COUNT];
  spss_pkg::phase_e phase;
  slot_t            move_slot;

  servo_word_t servo_words_due [$];

  int unsigned in_idle_pct  = 0;
  int unsigned out_idle_pct = 0;
  bit          hold_req     = 1'b0;
  int unsigned hold_left    = 0;
  int unsigned carried_cnt  = 0;
  int unsigned ignored_cnt  = 0;
  int unsigned checked_cnt  = 0;
  int unsigned fail_cnt     = 0;
  int unsigned cycle_cnt    = 0;

  always begin
    clk_i = 1'b0;
    #10;
    clk_i = 1'b1;
    #10;
  end

  function automatic spss_pkg::angle_t limit_angle(input spss_pkg::angle_t a);
    if (a > spss_pkg::ANGLE_MAX) return spss_pkg::ANGLE_MAX;
    return a;
  endfunction

  function automatic spss_pkg::angle_t leg_target();
    case (phase)
      spss_pkg::PH_LIFT:  return limit_angle(lift_reg);
      spss_pkg::PH_HSLEW: return preset_mem[2*move_slot];
      default:            return preset_mem[2*move_slot+1];
    endcase
  endfunction

  function automatic void skip_done_legs();
    while (phase != spss_pkg::PH_IDLE &&
           (phase == spss_pkg::PH_HSLEW ? pos_h : pos_v) == leg_target()) begin
      case (phase)
        spss_pkg::PH_LIFT:  phase = spss_pkg::PH_HSLEW;
        spss_pkg::PH_HSLEW: phase = spss_pkg::PH_VSLEW;
        default:            phase = spss_pkg::PH_IDLE;
      endcase
    end
  endfunction

  function automatic servo_word_t next_servo_word(input spss_pkg::cmd_e c, input slot_t sel,
                                                  input spss_pkg::angle_t hv,
                                                  input spss_pkg::angle_t vv);
    servo_word_t      w;
    spss_pkg::angle_t goal;
    w.acc = 1'b0;
    if (c == spss_pkg::CMD_TICK) begin
      if (phase != spss_pkg::PH_IDLE) begin
        goal = leg_target();
        if (phase == spss_pkg::PH_HSLEW) begin
          if (pos_h < goal) pos_h = pos_h + 8'd1;
          else if (pos_h > goal) pos_h = pos_h - 8'd1;
        end else begin
          if (pos_v < goal) pos_v = pos_v + 8'd1;
          else if (pos_v > goal) pos_v = pos_v - 8'd1;
        end
        skip_done_legs();
      end
      w.acc = 1'b1;
    end else if (phase == spss_pkg::PH_IDLE && c == spss_pkg::CMD_CENTRE) begin
      pos_h = limit_angle(centre_h_reg);
      pos_v = limit_angle(centre_v_reg);
      w.acc = 1'b1;
    end else if (phase == spss_pkg::PH_IDLE && sel < spss_pkg::PRESET_COUNT) begin
      if (c == spss_pkg::CMD_GO) begin
        move_slot = sel;
        phase = spss_pkg::PH_LIFT;
        skip_done_legs();
      end else begin
        preset_mem[2*sel]   = limit_angle(hv);
        preset_mem[2*sel+1] = limit_angle(vv);
      end
      w.acc = 1'b1;
    end
    w.hor  = pos_h;
    w.ver  = pos_v;
    w.busy = (phase != spss_pkg::PH_IDLE);
    return w;
  endfunction

  // Called just after a falling edge; returns just after the falling edge that follows acceptance.
  task automatic send_word(input spss_pkg::cmd_e c, input slot_t sel,
                           input spss_pkg::angle_t hv, input spss_pkg::angle_t vv,
                           input bit typed = 1'b0, input servo_word_t want = '0);
    servo_word_t w;
    while ($urandom_range(99) < in_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i         <= 1'b1;
    cmd_i              <= c;
    preset_select_i    <= sel;
    horizontal_value_i <= hv;
    vertical_value_i   <= vv;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    w = next_servo_word(c, sel, hv, vv);
    if (w.acc) carried_cnt++;
    else ignored_cnt++;
    servo_words_due.push_back(typed ? want : w);
    @(negedge clk_i);
  endtask

  // Finish any move, drop valid and let the pipeline empty.
  task automatic settle();
    while (phase != spss_pkg::PH_IDLE)
      send_word(spss_pkg::CMD_TICK, slot_t'($urandom_range(3)),
                spss_pkg::angle_t'($urandom_range(255)),
                spss_pkg::angle_t'($urandom_range(255)));
    in_valid_i <= 1'b0;
    while (servo_words_due.size() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic write_reg(input spss_pkg::cfg_idx_e idx, input spss_pkg::angle_t val);
    settle();
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      spss_pkg::CFG_LIFT:     lift_reg = val;
      spss_pkg::CFG_CENTRE_H: centre_h_reg = val;
      spss_pkg::CFG_CENTRE_V: centre_v_reg = val;
      default: ;
    endcase
  endtask

  function automatic spss_pkg::angle_t near_angle(input spss_pkg::angle_t anchor);
    int a;
    if ($urandom_range(99) < 15) return spss_pkg::angle_t'($urandom_range(255));
    a = int'(anchor) + int'($urandom_range(12)) - 6;
    if (a < 0) a = 0;
    if (a > 255) a = 255;
    return spss_pkg::angle_t'(a);
  endfunction

  // Mostly store/go/tick sequences with short moves; noise words mixed in.
  task automatic run_moves(input int unsigned quota);
    int unsigned first;
    slot_t       slot;
    first = carried_cnt;
    while (carried_cnt - first < quota) begin
      if ($urandom_range(99) < 70) begin
        slot = slot_t'($urandom_range(spss_pkg::PRESET_COUNT - 1));
        send_word(spss_pkg::CMD_STORE, slot, near_angle(pos_h),
                  near_angle(limit_angle(lift_reg)));
        send_word(spss_pkg::CMD_GO, slot, spss_pkg::angle_t'($urandom_range(255)),
                  spss_pkg::angle_t'($urandom_range(255)));
        while (phase != spss_pkg::PH_IDLE) begin
          if ($urandom_range(9) == 0)
            send_word(spss_pkg::cmd_e'($urandom_range(3, 1)), slot_t'($urandom_range(3)),
                      spss_pkg::angle_t'($urandom_range(255)),
                      spss_pkg::angle_t'($urandom_range(255)));
          else
            send_word(spss_pkg::CMD_TICK, slot_t'($urandom_range(3)),
                      spss_pkg::angle_t'($urandom_range(255)),
                      spss_pkg::angle_t'($urandom_range(255)));
        end
      end else begin
        send_word(spss_pkg::cmd_e'($urandom_range(3)), slot_t'($urandom_range(3)),
                  spss_pkg::angle_t'($urandom_range(255)),
                  spss_pkg::angle_t'($urandom_range(255)));
      end
    end
  endtask

  initial begin
    out_stall_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        hold_left = HOLD_CYCLES;
        hold_req  = 1'b0;
      end
      if (hold_left > 0) begin
        out_stall_i <= 1'b1;
        hold_left--;
      end else begin
        out_stall_i <= ($urandom_range(99) < out_idle_pct);
      end
    end
  end

  always @(posedge clk_i) begin : word_check
    servo_word_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      checked_cnt++;
      if (servo_words_due.size() == 0) begin
        $error("unexpected word: h %0d v %0d busy %0d acc %0d", horizontal_angle_o,
               vertical_angle_o, busy_res_o, accepted_o);
        fail_cnt++;
      end else begin
        want = servo_words_due.pop_front();
        if (horizontal_angle_o !== want.hor) begin
          $error("horizontal_angle: expected %0d, got %0d", want.hor, horizontal_angle_o);
          fail_cnt++;
        end
        if (vertical_angle_o !== want.ver) begin
          $error("vertical_angle: expected %0d, got %0d", want.ver, vertical_angle_o);
          fail_cnt++;
        end
        if (busy_res_o !== want.busy) begin
          $error("busy_res: expected %0d, got %0d", want.busy, busy_res_o);
          fail_cnt++;
        end
        if (accepted_o !== want.acc) begin
          $error("accepted: expected %0d, got %0d", want.acc, accepted_o);
          fail_cnt++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d words outstanding", cycle_cnt,
               servo_words_due.size());
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    rst_ni             = 1'b0;
    in_valid_i         = 1'b0;
    cmd_i              = spss_pkg::CMD_TICK;
    preset_select_i    = '0;
    horizontal_value_i = '0;
    vertical_value_i   = '0;
    cfg_we_i           = 1'b0;
    cfg_index_i        = spss_pkg::CFG_NONE;
    cfg_data_i         = '0;
    lift_reg           = spss_pkg::LIFT_RESET;
    centre_h_reg       = spss_pkg::CENTRE_H_RESET;
    centre_v_reg       = spss_pkg::CENTRE_V_RESET;
    pos_h              = 8'd90;
    pos_v              = 8'd45;
    for (int k = 0; k < 2*spss_pkg::PRESET_COUNT; k++) preset_mem[k] = '0;
    phase              = spss_pkg::PH_IDLE;
    move_slot          = '0;
    repeat (10) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    for (int r = 0; r < PLAN_LEN; r++) begin
      if (PLAN[r].is_reg)
        write_reg(PLAN[r].reg_idx, PLAN[r].hval);
      else
        send_word(PLAN[r].cmd, PLAN[r].sel, PLAN[r].hval, PLAN[r].vval, PLAN[r].typed,
                  PLAN[r].want);
    end

    write_reg(spss_pkg::CFG_LIFT, 8'd0);
    write_reg(spss_pkg::CFG_CENTRE_H, 8'd180);
    write_reg(spss_pkg::CFG_CENTRE_V, 8'd255);
    in_idle_pct  = 15;
    out_idle_pct = 73;
    run_moves(PHASE_WORDS);

    write_reg(spss_pkg::CFG_LIFT, 8'd255);
    write_reg(spss_pkg::CFG_CENTRE_H, 8'd0);
    write_reg(spss_pkg::CFG_CENTRE_V, 8'd0);
    write_reg(spss_pkg::CFG_NONE, 8'd77);
    in_idle_pct  = 73;
    out_idle_pct = 15;
    run_moves(PHASE_WORDS);

    write_reg(spss_pkg::CFG_LIFT, 8'd130);
    write_reg(spss_pkg::CFG_CENTRE_H, 8'd200);
    write_reg(spss_pkg::CFG_CENTRE_V, 8'd90);
    in_idle_pct  = 0;
    out_idle_pct = 0;
    hold_req     = 1'b1;
    run_moves(PHASE_WORDS);

    settle();
    repeat (8) @(posedge clk_i);
    $display("Sent %0d words (%0d carried out, %0d ignored) over four register settings,",
             carried_cnt + ignored_cnt, carried_cnt, ignored_cnt);
    $display("three idle/stall mixes and one long output hold; %0d words checked, %0d errors.",
             checked_cnt, fail_cnt);
    if (fail_cnt == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
